// ----- rtl/core/gcr_pkg.sv -----
package gcr_pkg;

  // Glyph geometry is fixed: one font row is one byte, row bit 7 is the leftmost pixel.
  localparam int GLYPH_SIZE = 8;
  localparam int GLYPH_COUNT_DEF = 256;
  localparam int CURSOR_SIZE = 6;
  localparam logic [31:0] CURSOR_MASK = 32'h00FF_FFFF;

  typedef enum logic [1:0] {
    CMD_GLYPH  = 2'd0,
    CMD_CURSOR = 2'd1,
    CMD_PIXEL  = 2'd2,
    CMD_LOAD   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_BASE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_PITCH  = 2'd3
  } cfg_idx_e;

endpackage

// ----- rtl/core/glyph_and_cursor_rasterizer.sv -----
// Glyph and cursor rasterizer.
// Input stream (s_*): one draw command per transfer; s_tuser_i carries the command kind.
// Output stream (m_*): framebuffer write requests; m_tlast_o marks the final write of a
// command, m_tuser_o says the data is an XOR mask rather than a plain value.
// Config port: cfg_we_i writes cfg_wdata_i into the register selected by cfg_idx_i
// (0 base, 1 width, 2 height, 3 pitch); write only while idle. A base of zero disables drawing.
// A font load is taken and emits nothing. A draw command passes through a row-offset
// multiply state and a start address state, then scans each glyph cell (8x8 glyph,
// CURSOR_SIZE squared cursor, one cell for a pixel) and then flushes the last write.
// The pixel scan steps one cell per cycle, unless stalled, through a column address adder,
// a row address adder and a clip compare.
// Each write found is held back until the next one is found or the command ends, so its
// last flag is known when it is passed on.
// If the receiver stalls, the scan holds once a new write is found while one is queued and
// the output is full; s_tready_o is low for the whole command.
// Reset clears the config registers, the valid flags and the control state. The font
// store is not cleared: draw only glyph rows that were loaded.
module glyph_and_cursor_rasterizer #(
  parameter int GLYPH_COUNT = gcr_pkg::GLYPH_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // pos_x[15:0], pos_y[31:16], char_code[39:32], row_index[42:40], row_bits[50:43],
  // color[82:51], zero fill above
  input  logic [87:0] s_tdata_i,
  // cmd[1:0]
  input  logic [1:0]  s_tuser_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // word_addr[31:0], pixel_data[63:32]
  output logic [63:0] m_tdata_o,
  // is_xor[0]
  output logic        m_tuser_o,
  output logic        m_tlast_o
);

  localparam int FontDepth = GLYPH_COUNT * gcr_pkg::GLYPH_SIZE;
  localparam int IdxW = $clog2(FontDepth);
  localparam logic [2:0] GlyphLast = 3'(gcr_pkg::GLYPH_SIZE - 1);
  localparam logic [2:0] CursorLast = 3'(gcr_pkg::CURSOR_SIZE - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_BASE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e state_q;

  logic [31:0] base_q;
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [15:0] pitch_q;

  gcr_pkg::cmd_e cmd_q;
  logic signed [15:0] x0_q;
  logic signed [15:0] y0_q;
  logic [7:0]  code_q;
  logic [31:0] data_q;
  logic        xor_q;
  logic [2:0]  last_idx_q;

  logic signed [31:0] prod_q;
  logic [31:0] row_start_q;
  logic [31:0] col_addr_q;
  logic signed [16:0] cx_q;
  logic signed [16:0] cy_q;
  logic [2:0]  row_q;
  logic [2:0]  row_d;
  logic [2:0]  col_q;

  logic        pend_v_q;
  logic [31:0] pend_addr_q;
  logic [31:0] pend_data_q;
  logic        pend_xor_q;

  logic        out_v_q;
  logic [31:0] out_addr_q;
  logic [31:0] out_data_q;
  logic        out_xor_q;
  logic        out_last_q;

  logic [7:0]  font_mem [FontDepth];
  logic [7:0]  font_row_q;

  gcr_pkg::cmd_e in_cmd;
  logic [7:0]  in_code;
  logic [2:0]  in_row;
  logic        in_code_ok;
  logic        load_we;
  logic        pix_on;
  logic        visible;
  logic        hit;
  logic        out_free;
  logic        adv;
  logic        out_load;
  logic        row_end;
  logic [31:0] next_row;

  assign in_cmd     = gcr_pkg::cmd_e'(s_tuser_i);
  assign in_code    = s_tdata_i[39:32];
  assign in_row     = s_tdata_i[42:40];
  assign in_code_ok = {1'b0, in_code} < 9'(GLYPH_COUNT);
  assign load_we    = s_tvalid_i && s_tready_o && (in_cmd == gcr_pkg::CMD_LOAD) && in_code_ok;

  assign pix_on  = (cmd_q == gcr_pkg::CMD_GLYPH) ? font_row_q[~col_q] : 1'b1;
  assign visible = !cx_q[16] && !cy_q[16] &&
                   (cx_q < $signed({4'b0, width_q})) && (cy_q < $signed({4'b0, height_q}));
  assign hit      = (state_q == ST_SCAN) && pix_on && visible;
  assign out_free = !out_v_q || m_tready_i;
  // stall only when a new write needs the queued one moved out and the output is full
  assign adv      = !(hit && pend_v_q && !out_free);
  // output register takes the queued write on a new hit or at the end of the command
  assign out_load = (hit && pend_v_q && adv) ||
                    ((state_q == ST_FLUSH) && pend_v_q && out_free);
  assign row_end  = (col_q == last_idx_q);
  assign next_row = row_start_q + {16'b0, pitch_q[15:2], 2'b00};

  always_comb begin
    row_d = row_q;
    case (state_q)
      ST_BASE: row_d = 3'd0;
      ST_SCAN: if (adv && row_end && (row_q != last_idx_q)) begin
        row_d = row_q + 3'd1;
      end
      default: row_d = row_q;
    endcase
  end

  // font store: read address follows the next row so the row is ready when scanned
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      font_mem[IdxW'({in_code, in_row})] <= s_tdata_i[50:43];
    end
    font_row_q <= font_mem[IdxW'({code_q, row_d})];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      base_q   <= '0;
      width_q  <= '0;
      height_q <= '0;
      pitch_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (gcr_pkg::cfg_idx_e'(cfg_idx_i))
          gcr_pkg::CFG_BASE:   base_q   <= cfg_wdata_i;
          gcr_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i[12:0];
          gcr_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i[12:0];
          gcr_pkg::CFG_PITCH:  pitch_q  <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && m_tready_i) begin
        out_v_q <= 1'b0;
      end

      row_q <= row_d;

      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            cmd_q  <= in_cmd;
            x0_q   <= s_tdata_i[15:0];
            y0_q   <= s_tdata_i[31:16];
            code_q <= in_code;
            data_q <= (in_cmd == gcr_pkg::CMD_CURSOR) ? gcr_pkg::CURSOR_MASK
                                                       : s_tdata_i[82:51];
            xor_q  <= (in_cmd == gcr_pkg::CMD_CURSOR);
            case (in_cmd)
              gcr_pkg::CMD_GLYPH:  last_idx_q <= GlyphLast;
              gcr_pkg::CMD_CURSOR: last_idx_q <= CursorLast;
              default:             last_idx_q <= 3'd0;
            endcase
            if ((in_cmd != gcr_pkg::CMD_LOAD) && (base_q != '0) &&
                !((in_cmd == gcr_pkg::CMD_GLYPH) && !in_code_ok)) begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_q  <= y0_q * $signed({2'b0, pitch_q[15:2]});
          state_q <= ST_BASE;
        end
        ST_BASE: begin
          row_start_q <= base_q + ((prod_q + 32'(x0_q)) << 2);
          col_addr_q  <= base_q + ((prod_q + 32'(x0_q)) << 2);
          cx_q        <= 17'(x0_q);
          cy_q        <= 17'(y0_q);
          col_q       <= 3'd0;
          state_q     <= ST_SCAN;
        end
        ST_SCAN: begin
          if (adv) begin
            if (hit) begin
              if (pend_v_q) begin
                out_addr_q <= pend_addr_q;
                out_data_q <= pend_data_q;
                out_xor_q  <= pend_xor_q;
                out_last_q <= 1'b0;
              end
              pend_addr_q <= col_addr_q;
              pend_data_q <= data_q;
              pend_xor_q  <= xor_q;
              pend_v_q    <= 1'b1;
            end
            if (row_end) begin
              col_q       <= 3'd0;
              cx_q        <= 17'(x0_q);
              cy_q        <= cy_q + 17'sd1;
              row_start_q <= next_row;
              col_addr_q  <= next_row;
              if (row_q == last_idx_q) begin
                state_q <= ST_FLUSH;
              end
            end else begin
              col_q      <= col_q + 3'd1;
              cx_q       <= cx_q + 17'sd1;
              col_addr_q <= col_addr_q + 32'd4;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_addr_q <= pend_addr_q;
            out_data_q <= pend_data_q;
            out_xor_q  <= pend_xor_q;
            out_last_q <= 1'b1;
            pend_v_q   <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = {out_data_q, out_addr_q};
  assign m_tuser_o  = out_xor_q;
  assign m_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("queued write left behind at command end");

  a_stall_holds_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !adv) |=> ($stable(col_q) && $stable(row_q) && $stable(col_addr_q)))
    else $error("scan moved while stalled");

  a_hit_pushes_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit && pend_v_q && adv) |=> (m_tvalid_o && !m_tlast_o && pend_v_q))
    else $error("queued write not passed on by a new hit");
`endif

endmodule
